@@ rtl/mas_pkg.sv @@
package mas_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 3;
  localparam int DIM_W  = 4;
  localparam int OP_W   = 3;
  localparam int CFG_IDX_W = 4;

  localparam logic [OP_W-1:0] OP_LOAD_A = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD    = 3'd2;
  localparam logic [OP_W-1:0] OP_SUB    = 3'd3;
  localparam logic [OP_W-1:0] OP_MUL    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_A = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_B = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 4'd3;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [DATA_W-1:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic [IDX_W-1:0]         result_row;
    logic [IDX_W-1:0]         result_col;
    logic                     status;
    logic                     last;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic             we_a;
    logic             we_b;
    logic             rd_valid;
    logic             err;
    logic             op_mul;
    logic             op_sub;
    logic             first;
    logic             last_k;
    logic             last_el;
    logic [IDX_W-1:0] row_a;
    logic [IDX_W-1:0] col_a;
    logic [IDX_W-1:0] row_b;
    logic [IDX_W-1:0] col_b;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pipe_busy;
  } dp_status_t;

endpackage

@@ rtl/mas_ram.sv @@
module mas_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  logic [WIDTH-1:0]       wdata,
  input  logic [AW-1:0]          raddr,
  output logic [WIDTH-1:0]       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/mas_ctrl.sv @@
module mas_ctrl #(
  parameter int MAX_DIM = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  mas_pkg::in_item_t                  item,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mas_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mas_pkg::DIM_W-1:0]          cfg_data,
  input  mas_pkg::dp_status_t                dp_status,
  output mas_pkg::ctl_cmd_t                  cmd
);

  localparam int CAP_I = (MAX_DIM < 8) ? MAX_DIM : 8;
  localparam logic [mas_pkg::DIM_W-1:0] CAP = mas_pkg::DIM_W'(CAP_I);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  function automatic logic [mas_pkg::DIM_W-1:0] eff(input logic [mas_pkg::DIM_W-1:0] v);
    logic [mas_pkg::DIM_W-1:0] r;
    if (v == '0) begin
      r = 4'd1;
    end else if (v > CAP) begin
      r = CAP;
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic                            state;
  logic                            state_next;
  logic [mas_pkg::DIM_W-1:0]       rows_a, cols_a, rows_b, cols_b;
  logic [mas_pkg::DIM_W-1:0]       nr, nc, nk;
  logic                            op_mul, op_sub;
  logic [mas_pkg::IDX_W-1:0]       i, j, k;

  logic                            accept;
  logic                            in_range;
  logic                            is_mul, is_addsub, conform;
  logic [mas_pkg::DIM_W-1:0]       ra, ca, rb, cb;
  logic                            end_k, end_j, end_i;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign busy      = (state == ST_RUN) || dp_status.pipe_busy;

  assign ra = eff(rows_a);
  assign ca = eff(cols_a);
  assign rb = eff(rows_b);
  assign cb = eff(cols_b);

  assign in_range  = (int'(item.row_index) < MAX_DIM) && (int'(item.col_index) < MAX_DIM);
  assign is_mul    = (item.opcode == mas_pkg::OP_MUL);
  assign is_addsub = (item.opcode == mas_pkg::OP_ADD) || (item.opcode == mas_pkg::OP_SUB);
  assign conform   = is_mul ? (ca == rb) : ((ra == rb) && (ca == cb));

  assign end_k = (mas_pkg::DIM_W'(k) + 4'd1) == nk;
  assign end_j = (mas_pkg::DIM_W'(j) + 4'd1) == nc;
  assign end_i = (mas_pkg::DIM_W'(i) + 4'd1) == nr;

  always_comb begin
    cmd         = '0;
    cmd.we_a    = accept && (item.opcode == mas_pkg::OP_LOAD_A) && in_range;
    cmd.we_b    = accept && (item.opcode == mas_pkg::OP_LOAD_B) && in_range;
    cmd.err     = accept && (is_mul || is_addsub) && !conform;
    cmd.op_mul  = op_mul;
    cmd.op_sub  = op_sub;
    cmd.first   = (k == '0);
    cmd.last_k  = end_k;
    cmd.last_el = end_k && end_j && end_i;
    cmd.row_a   = i;
    cmd.col_a   = op_mul ? k : j;
    cmd.row_b   = op_mul ? k : i;
    cmd.col_b   = j;
    cmd.rd_valid = (state == ST_RUN);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (is_mul || is_addsub) && conform) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (end_k && end_j && end_i) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      rows_a <= mas_pkg::DIM_RESET;
      cols_a <= mas_pkg::DIM_RESET;
      rows_b <= mas_pkg::DIM_RESET;
      cols_b <= mas_pkg::DIM_RESET;
      i      <= '0;
      j      <= '0;
      k      <= '0;
      op_mul <= 1'b0;
      op_sub <= 1'b0;
      nr     <= 4'd1;
      nc     <= 4'd1;
      nk     <= 4'd1;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        case (cfg_index)
          mas_pkg::REG_ROWS_A: rows_a <= cfg_data;
          mas_pkg::REG_COLS_A: cols_a <= cfg_data;
          mas_pkg::REG_ROWS_B: rows_b <= cfg_data;
          mas_pkg::REG_COLS_B: cols_b <= cfg_data;
          default: ;
        endcase
      end
      if (state == ST_IDLE) begin
        if (accept && (is_mul || is_addsub) && conform) begin
          op_mul <= is_mul;
          op_sub <= (item.opcode == mas_pkg::OP_SUB);
          nr     <= ra;
          nc     <= is_mul ? cb : ca;
          nk     <= is_mul ? ca : 4'd1;   // add/sub: one step per element
          i      <= '0;
          j      <= '0;
          k      <= '0;
        end
      end else begin
        if (end_k) begin
          k <= '0;
          if (end_j) begin
            j <= '0;
            i <= i + 3'd1;
          end else begin
            j <= j + 3'd1;
          end
        end else begin
          k <= k + 3'd1;
        end
      end
    end
  end

endmodule

@@ rtl/mas_dp.sv @@
module mas_dp #(
  parameter int MAX_DIM = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  mas_pkg::in_item_t   item,
  input  mas_pkg::ctl_cmd_t   cmd,
  output mas_pkg::dp_status_t dp_status,
  output mas_pkg::result_t    result,
  output logic                result_strobe
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  function automatic logic [AW-1:0] mk_addr(input logic [mas_pkg::IDX_W-1:0] r,
                                            input logic [mas_pkg::IDX_W-1:0] c);
    return AW'(r) * AW'(MAX_DIM) + AW'(c);
  endfunction

  logic [mas_pkg::DATA_W-1:0] a_rdata, b_rdata;
  logic [AW-1:0]              waddr;

  // read stage (RAM output valid alongside these)
  logic                       s1_valid, s1_err, s1_mul, s1_sub;
  logic                       s1_first, s1_last_k, s1_last_el;
  logic [mas_pkg::IDX_W-1:0]  s1_row, s1_col;
  logic [mas_pkg::DATA_W-1:0] s1_val;

  // operation stage
  logic                       s2_valid, s2_err;
  logic                       s2_first, s2_last_k, s2_last_el;
  logic [mas_pkg::IDX_W-1:0]  s2_row, s2_col;
  logic [mas_pkg::DATA_W-1:0] s2_val;

  logic [mas_pkg::DATA_W-1:0] acc;
  logic [mas_pkg::DATA_W-1:0] acc_sum;

  assign waddr = mk_addr(item.row_index, item.col_index);

  mas_ram #(.WIDTH(mas_pkg::DATA_W), .DEPTH(DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (cmd.we_a),
    .waddr (waddr),
    .wdata (item.element_value),
    .raddr (mk_addr(cmd.row_a, cmd.col_a)),
    .rdata (a_rdata)
  );

  mas_ram #(.WIDTH(mas_pkg::DATA_W), .DEPTH(DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (cmd.we_b),
    .waddr (waddr),
    .wdata (item.element_value),
    .raddr (mk_addr(cmd.row_b, cmd.col_b)),
    .rdata (b_rdata)
  );

  always_comb begin
    if (s1_mul) begin
      s1_val = a_rdata * b_rdata;   // low 32 bits of the product
    end else if (s1_sub) begin
      s1_val = a_rdata - b_rdata;
    end else begin
      s1_val = a_rdata + b_rdata;
    end
  end

  assign acc_sum = s2_first ? s2_val : acc + s2_val;
  assign dp_status.pipe_busy = s1_valid || s2_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      s1_valid      <= cmd.rd_valid || cmd.err;
      s2_valid      <= s1_valid;
      result_strobe <= s2_valid && (s2_err || s2_last_k);
    end
  end

  always_ff @(posedge clk) begin
    s1_err     <= cmd.err;
    s1_mul     <= cmd.op_mul;
    s1_sub     <= cmd.op_sub;
    s1_first   <= cmd.first;
    s1_last_k  <= cmd.last_k;
    s1_last_el <= cmd.last_el;
    s1_row     <= cmd.row_a;
    s1_col     <= cmd.col_b;

    s2_err     <= s1_err;
    s2_first   <= s1_first;
    s2_last_k  <= s1_last_k;
    s2_last_el <= s1_last_el;
    s2_row     <= s1_row;
    s2_col     <= s1_col;
    s2_val     <= s1_val;

    if (s2_valid) begin
      acc <= acc_sum;
    end

    if (s2_err) begin
      result.result_value <= '0;
      result.result_row   <= '0;
      result.result_col   <= '0;
      result.status       <= 1'b1;
      result.last         <= 1'b1;
    end else begin
      result.result_value <= acc_sum;
      result.result_row   <= s2_row;
      result.result_col   <= s2_col;
      result.status       <= 1'b0;
      result.last         <= s2_last_el;
    end
  end

endmodule

@@ rtl/matrix_add_sub_multiply.sv @@
// Integer matrix engine: load items write A or B one element per cycle while
// busy is low; add, subtract and multiply items stream the result matrix
// row-major, one item per result_strobe pulse, which the receiver must take in
// that cycle. Add/subtract read each element pair through the read, operation
// and result registers, one result per cycle. Multiply accumulates cols_a
// products per result: a single multiply-accumulate unit fed by one read port
// per store does one product a cycle. A not-conformable request gives its
// single status item through the same registers. busy stays high until the last
// result is on the ports. The stores are not cleared by reset.
module matrix_add_sub_multiply #(
  parameter int MAX_DIM = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  mas_pkg::in_item_t              in_item,
  output mas_pkg::result_t               result,
  output logic                           result_strobe,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mas_pkg::DIM_W-1:0]      cfg_data
);

  mas_pkg::ctl_cmd_t   cmd;
  mas_pkg::dp_status_t dp_status;

  mas_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .dp_status (dp_status),
    .cmd       (cmd)
  );

  mas_dp #(.MAX_DIM(MAX_DIM)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .item          (in_item),
    .cmd           (cmd),
    .dp_status     (dp_status),
    .result        (result),
    .result_strobe (result_strobe)
  );

endmodule
